// ===== rtl/core/riff_wave_chunk_parser_assert.svh =====
// assertion macros for the riff wave chunk parser
// used by the top level only, no other dependencies
`ifndef RIFF_WAVE_CHUNK_PARSER_ASSERT_SVH
`define RIFF_WAVE_CHUNK_PARSER_ASSERT_SVH

// same-cycle implication
`define RWCP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rwcp same-cycle check failed");

// next-cycle implication
`define RWCP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rwcp next-cycle check failed");

`endif

// ===== rtl/core/rwcp_pkg.sv =====
// shared types and constants of the riff wave chunk parser
// no dependencies; used by every module of the block
package rwcp_pkg;

    localparam logic [31:0] ID_FMT     = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA    = 32'h6174_6164;
    localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
    localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;

    localparam logic [15:0] FORMAT_TAG_RESET = 16'd1;
    localparam int unsigned APB_ADDR_W = 3;

    typedef enum logic [6:0] {
        PH_HEADER    = 7'b0000001,
        PH_CHUNK_HDR = 7'b0000010,
        PH_FMT       = 7'b0000100,
        PH_DATA      = 7'b0001000,
        PH_SKIP      = 7'b0010000,
        PH_PAD       = 7'b0100000,
        PH_FINISHED  = 7'b1000000
    } rwcp_phase_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_MAGIC  = 2'd1,
        ERR_FORMAT = 2'd2,
        ERR_TRUNC  = 2'd3
    } rwcp_err_t;

    typedef enum logic [0:0] {
        REG_FORMAT_TAG = 1'b0
    } rwcp_reg_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       start_of_file;
        logic       end_of_file;
    } rwcp_item_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       parse_done;
        rwcp_err_t  error_code;
    } rwcp_result_t;

endpackage

// ===== rtl/core/riff_wave_chunk_parser.sv =====
// top level of the riff wave chunk parser
// depends on rwcp_pkg, rwcp_in_stage, rwcp_cfg_regs, rwcp_parser and the assert header
//
// usage:
// - input channel (s_*): one byte of a wave file per item, with start_of_file on
//   the first byte of a file and end_of_file on the last byte available
// - result channel (m_*): an item for every data chunk byte and one more flag
//   parse_done with error_code when the parse finishes (both may share an item)
// - bytes that give no result are consumed silently
// - apb port: register 0 at byte address 0 holds the accepted format tag
// - a result is registered: its byte sits in the input register, then parse logic
//   loads the result register
// - throughput: one byte per cycle while m_ready is high, set by the phase and counter
//   update, combinational between the input register and the result register
// - stall: while m_ready is low the result register holds, one more byte waits
//   in the input register and s_ready then drops
// - reset: parse returns to the file header phase, format tag returns to 1,
//   both registers empty
// - after a finish, bytes are dropped until the next start_of_file
`include "riff_wave_chunk_parser_assert.svh"

module riff_wave_chunk_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_byte_in,
    input  logic                            s_start_of_file,
    input  logic                            s_end_of_file,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_payload_valid,
    output logic [7:0]                      m_payload_byte,
    output logic                            m_parse_done,
    output logic [1:0]                      m_error_code,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rwcp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    rwcp_pkg::rwcp_item_t   s_item;
    rwcp_pkg::rwcp_item_t   item;
    rwcp_pkg::rwcp_result_t result;
    logic                   item_valid;
    logic                   advance;
    logic [15:0]            format_tag;
    logic                   tag_write;

    assign s_item.byte_in       = s_byte_in;
    assign s_item.start_of_file = s_start_of_file;
    assign s_item.end_of_file   = s_end_of_file;

    assign m_payload_valid = result.payload_valid;
    assign m_payload_byte  = result.payload_byte;
    assign m_parse_done    = result.parse_done;
    assign m_error_code    = result.error_code;

    assign tag_write = psel && penable && pwrite
                       && (paddr[rwcp_pkg::APB_ADDR_W-1] == rwcp_pkg::REG_FORMAT_TAG);

    rwcp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rwcp_cfg_regs u_cfg_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .format_tag (format_tag)
    );

    rwcp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .format_tag (format_tag),
        .advance    (advance),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .result     (result)
    );

    `RWCP_ASSERT_NOW(a_ready_when_out_empty, aclk, aresetn, !m_valid, s_ready)
    `RWCP_ASSERT_NOW(a_result_not_empty, aclk, aresetn, m_valid, m_payload_valid || m_parse_done)
    `RWCP_ASSERT_NEXT(a_tag_written, aclk, aresetn, tag_write, format_tag == $past(pwdata[15:0]))

endmodule

// ===== rtl/core/rwcp_in_stage.sv =====
// input register of the riff wave chunk parser
// depends on rwcp_pkg for the item type
module rwcp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rwcp_pkg::rwcp_item_t s_item,
    input  logic              advance,
    output logic              item_valid,
    output rwcp_pkg::rwcp_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    rwcp_pkg::rwcp_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== rtl/core/rwcp_cfg_regs.sv =====
// apb configuration register of the riff wave chunk parser
// depends on rwcp_pkg for the register map and reset value
module rwcp_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rwcp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [15:0]                     format_tag
);

    logic [15:0] tag_reg;
    logic        sel_tag;

    assign pready     = 1'b1;
    assign sel_tag    = paddr[rwcp_pkg::APB_ADDR_W-1] == rwcp_pkg::REG_FORMAT_TAG;
    assign format_tag = tag_reg;
    assign prdata     = sel_tag ? {16'd0, tag_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= rwcp_pkg::FORMAT_TAG_RESET;
        end else if (psel && penable && pwrite && pready && sel_tag) begin
            tag_reg <= pwdata[15:0];
        end
    end

endmodule

// ===== rtl/core/rwcp_parser.sv =====
// parse state, per-byte next-state logic and result register
// depends on rwcp_pkg for phases, error codes, ids and item types
module rwcp_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    input  rwcp_pkg::rwcp_item_t   item,
    input  logic [15:0]            format_tag,
    output logic                   advance,
    input  logic                   m_ready,
    output logic                   m_valid,
    output rwcp_pkg::rwcp_result_t result
);

    rwcp_pkg::rwcp_phase_t phase_reg, phase_next, ph;
    logic [3:0]  fcnt_reg, fcnt_next, fc;
    logic [33:0] rem_reg, rem_next, rem;
    logic [31:0] id_reg, id_next, id;
    logic [31:0] len_reg, len_next, len;
    logic [31:0] bl_reg, bl_next, bl;
    logic [7:0]  tag_reg, tag_next, tag;

    logic        out_valid_reg, out_valid_next;
    rwcp_pkg::rwcp_result_t res_reg, res;

    logic [7:0]  b;
    logic [31:0] lane_val, id_ins, len_ins, bl_dec, len_m1;
    logic [33:0] rem_body, rem_hdr, rem_wave, after_rem;
    logic        fin, pv, do_after, body_end, active;
    rwcp_pkg::rwcp_err_t code;

    function automatic logic le_zero(input logic [33:0] r);
        return r[33] || (r == 34'd0);
    endfunction

    assign advance = item_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign result  = res_reg;

    always_comb begin
        b   = item.byte_in;
        ph  = item.start_of_file ? rwcp_pkg::PH_HEADER : phase_reg;
        fc  = item.start_of_file ? 4'd0  : fcnt_reg;
        rem = item.start_of_file ? 34'd0 : rem_reg;
        id  = item.start_of_file ? 32'd0 : id_reg;
        len = item.start_of_file ? 32'd0 : len_reg;
        bl  = item.start_of_file ? 32'd0 : bl_reg;
        tag = item.start_of_file ? 8'd0  : tag_reg;

        phase_next = ph;
        fcnt_next  = fc;
        rem_next   = rem;
        id_next    = id;
        len_next   = len;
        bl_next    = bl;
        tag_next   = tag;

        fin       = 1'b0;
        code      = rwcp_pkg::ERR_NONE;
        pv        = 1'b0;
        do_after  = 1'b0;
        body_end  = 1'b0;
        active    = 1'b1;
        after_rem = rem;

        lane_val = {24'd0, b} << {fc[1:0], 3'b000};
        id_ins   = id | lane_val;
        len_ins  = len | lane_val;
        bl_dec   = bl - 32'd1;
        len_m1   = len - 32'd1;
        rem_body = rem - {2'b00, len} - {33'd0, len[0]};
        rem_hdr  = rem - 34'd8;
        rem_wave = {2'b00, len} - 34'd4;

        unique case (ph)
            rwcp_pkg::PH_HEADER: begin
                if (!fc[2] || fc[3]) begin
                    id_next = id_ins;
                end else begin
                    len_next = len_ins;
                end
                fcnt_next = fc + 4'd1;
                if (fc == 4'd3) begin
                    if (id_ins != rwcp_pkg::MAGIC_RIFF) begin
                        fin  = 1'b1;
                        code = rwcp_pkg::ERR_MAGIC;
                    end
                    id_next = 32'd0;
                end else if (fc >= 4'd11) begin
                    if (id_ins != rwcp_pkg::MAGIC_WAVE) begin
                        fin  = 1'b1;
                        code = rwcp_pkg::ERR_MAGIC;
                    end else begin
                        do_after  = 1'b1;
                        after_rem = rem_wave;
                    end
                end
            end
            rwcp_pkg::PH_CHUNK_HDR: begin
                if (!fc[2]) begin
                    id_next = id_ins;
                end else begin
                    len_next = len_ins;
                end
                fcnt_next = {1'b0, fc[2:0]} + 4'd1;
                if (fc[2:0] == 3'd7) begin
                    rem_next = rem_hdr;
                    bl_next  = len_ins;
                    tag_next = 8'd0;
                    if (id == rwcp_pkg::ID_FMT) begin
                        phase_next = rwcp_pkg::PH_FMT;
                    end else if (id == rwcp_pkg::ID_DATA) begin
                        phase_next = rwcp_pkg::PH_DATA;
                    end else begin
                        phase_next = rwcp_pkg::PH_SKIP;
                    end
                    // empty chunk ends right at its header
                    if (len_ins == 32'd0) begin
                        if (id == rwcp_pkg::ID_FMT) begin
                            fin  = 1'b1;
                            code = rwcp_pkg::ERR_FORMAT;
                        end else begin
                            do_after  = 1'b1;
                            after_rem = rem_hdr;
                        end
                    end
                end
            end
            rwcp_pkg::PH_FMT: begin
                bl_next = bl_dec;
                if (bl == len) begin
                    tag_next = b;
                end else if (bl == len_m1 && {b, tag} != format_tag) begin
                    fin  = 1'b1;
                    code = rwcp_pkg::ERR_FORMAT;
                end
                if (!fin && bl_dec == 32'd0) begin
                    body_end = 1'b1;
                end
            end
            rwcp_pkg::PH_DATA: begin
                pv      = 1'b1;
                bl_next = bl_dec;
                if (bl_dec == 32'd0) begin
                    body_end = 1'b1;
                end
            end
            rwcp_pkg::PH_SKIP: begin
                bl_next = bl_dec;
                if (bl_dec == 32'd0) begin
                    body_end = 1'b1;
                end
            end
            rwcp_pkg::PH_PAD: begin
                do_after  = 1'b1;
                after_rem = rem;
            end
            rwcp_pkg::PH_FINISHED: begin
                active = 1'b0;
            end
            default: begin
                phase_next = rwcp_pkg::PH_FINISHED;
                active     = 1'b0;
            end
        endcase

        if (body_end) begin
            if (id == rwcp_pkg::ID_FMT && len < 32'd2) begin
                fin  = 1'b1;
                code = rwcp_pkg::ERR_FORMAT;
            end else if (len[0]) begin
                phase_next = rwcp_pkg::PH_PAD;
                rem_next   = rem_body;
            end else begin
                do_after  = 1'b1;
                after_rem = rem_body;
            end
        end

        if (do_after) begin
            rem_next = after_rem;
            if (le_zero(after_rem)) begin
                fin  = 1'b1;
                code = rwcp_pkg::ERR_NONE;
            end else begin
                phase_next = rwcp_pkg::PH_CHUNK_HDR;
                fcnt_next  = 4'd0;
                id_next    = 32'd0;
                len_next   = 32'd0;
            end
        end

        if (active && item.end_of_file && !fin) begin
            fin  = 1'b1;
            code = rwcp_pkg::ERR_TRUNC;
        end

        if (fin) begin
            phase_next = rwcp_pkg::PH_FINISHED;
        end

        res.payload_valid = pv;
        res.payload_byte  = pv ? b : 8'd0;
        res.parse_done    = fin;
        res.error_code    = fin ? code : rwcp_pkg::ERR_NONE;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res.payload_valid || res.parse_done;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= rwcp_pkg::PH_HEADER;
            fcnt_reg      <= 4'd0;
            rem_reg       <= 34'd0;
            id_reg        <= 32'd0;
            len_reg       <= 32'd0;
            bl_reg        <= 32'd0;
            tag_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg <= phase_next;
                fcnt_reg  <= fcnt_next;
                rem_reg   <= rem_next;
                id_reg    <= id_next;
                len_reg   <= len_next;
                bl_reg    <= bl_next;
                tag_reg   <= tag_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

endmodule
